// ===== rtl/mth_pkg.sv =====
// Shared types, widths and codes for the motion trail point history block.
// Used by every module of the block; depends on nothing else.
package mth_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int POS_W    = 24;
  localparam int DT_W     = 20;
  localparam int TIME_W   = 48;
  localparam int LIFE_W   = 32;
  localparam int MAXL_W   = 31;
  localparam int MINS_W   = 20;
  localparam int IDX_W    = 6;
  localparam int COUNT_W  = 7;
  localparam int TOTAL_W  = 32;
  localparam int DIFF_W   = POS_W + 1;
  localparam int SQ_W     = 2 * POS_W + 1;
  localparam int D2_W     = 50;
  localparam int SEG_W    = D2_W / 2;
  localparam int ITER_W   = 5;
  localparam int CFG_A_W  = 3;
  localparam int CFG_D_W  = 32;
  localparam int IN_D_W   = 96;
  localparam int OUT_D_W  = 120;

  localparam logic [LIFE_W-1:0] LIFE_MIN   = LIFE_W'(1000);
  localparam logic [LIFE_W-1:0] LIFE_RESET = LIFE_W'(1000000);
  localparam logic [MINS_W-1:0] MINS_RESET = MINS_W'(1);
  localparam logic [TIME_W-1:0] TIME_MAX   = '1;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_EMITTING    = 3'd0,
    CFG_LIMIT_MODE  = 3'd1,
    CFG_LIFETIME    = 3'd2,
    CFG_MAX_LENGTH  = 3'd3,
    CFG_MIN_SECTION = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEW_RD,
    ST_NEW_GO,
    ST_NEW_DIST,
    ST_APPEND,
    ST_LT_RD,
    ST_LT_CHK,
    ST_SUM_RD,
    ST_SUM_GO,
    ST_SUM_SQ,
    ST_SUM_ROOT,
    ST_LEN_RD,
    ST_LEN_SUB,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  typedef struct packed {
    pos_t              pos;
    logic [TIME_W-1:0] stamp;
  } entry_t;

endpackage

// ===== rtl/mth_sqdist.sv =====
// Three-stage squared distance between two trail positions.
// Depends on mth_pkg for the position type and widths.
module mth_sqdist (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  mth_pkg::pos_t             pos_a,
  input  mth_pkg::pos_t             pos_b,
  output logic                      d2_valid,
  output logic [mth_pkg::D2_W-1:0]  d2
);

  logic signed [mth_pkg::DIFF_W-1:0] dx_r, dy_r, dz_r;
  logic [mth_pkg::SQ_W-1:0]          sx_r, sy_r, sz_r;
  logic signed [2*mth_pkg::DIFF_W-1:0] px, py, pz;
  logic [mth_pkg::D2_W-1:0]          d2_r;
  logic [2:0]                        vld_r;

  assign px = dx_r * dx_r;
  assign py = dy_r * dy_r;
  assign pz = dz_r * dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], start};
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= mth_pkg::DIFF_W'(pos_a.x) - mth_pkg::DIFF_W'(pos_b.x);
    dy_r <= mth_pkg::DIFF_W'(pos_a.y) - mth_pkg::DIFF_W'(pos_b.y);
    dz_r <= mth_pkg::DIFF_W'(pos_a.z) - mth_pkg::DIFF_W'(pos_b.z);
    sx_r <= px[mth_pkg::SQ_W-1:0];
    sy_r <= py[mth_pkg::SQ_W-1:0];
    sz_r <= pz[mth_pkg::SQ_W-1:0];
    d2_r <= mth_pkg::D2_W'(sx_r) + mth_pkg::D2_W'(sy_r) + mth_pkg::D2_W'(sz_r);
  end

  assign d2_valid = vld_r[2];
  assign d2       = d2_r;

endmodule

// ===== rtl/mth_isqrt.sv =====
// Iterative floor square root, one result bit per cycle.
// Depends on mth_pkg for the radicand and root widths.
module mth_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mth_pkg::D2_W-1:0]   radicand,
  output logic                       done,
  output logic [mth_pkg::SEG_W-1:0]  root
);

  logic [mth_pkg::D2_W-1:0]    rad_r;
  logic [mth_pkg::SEG_W:0]     rem_r;
  logic [mth_pkg::SEG_W-1:0]   root_r;
  logic [mth_pkg::ITER_W-1:0]  cnt_r;
  logic                        run_r, done_r;
  logic [mth_pkg::SEG_W+2:0]   rem_sh, trial;
  logic                        fit;

  assign rem_sh = {rem_r, rad_r[mth_pkg::D2_W-1 -: 2]};
  assign trial  = (mth_pkg::SEG_W+3)'({root_r, 2'b01});
  assign fit    = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == mth_pkg::ITER_W'(mth_pkg::SEG_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= fit ? (mth_pkg::SEG_W+1)'(rem_sh - trial) : rem_sh[mth_pkg::SEG_W:0];
      root_r <= {root_r[mth_pkg::SEG_W-2:0], fit};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/motion_trail_point_history.sv =====
// Top level of the motion trail point history: sequencer, point and segment memories.
// Depends on mth_pkg, mth_sqdist and mth_isqrt.
//
//  Channel | Dir | Handshake          | Payload
//  in_     | in  | in_tvalid/tready   | in_tdata: pos_x, pos_y, pos_z, delta_time; in_tuser: clear_first
//  out_    | out | out_tvalid/tready  | out_tdata: x, y, z, index, count, length; tuser, tlast
//  cfg_    | in  | cfg_we             | cfg_addr register index, cfg_wdata value
//
// One tick is taken at a time. After the accepting edge the sequencer runs, while
// emitting, the new-point test and append; then the lifetime checks if the limit mode
// is clear; then each polyline segment (read and start, the squared distance, the root
// steps and taking the root); the close of the sum; the length culling if the limit
// mode is set; and the emitted beats, one per retained point or a single empty beat.
// Reset is synchronous and active low; the memories need no clearing because only
// live entries are ever used. A stalled result register holds the emit sequencer.
module motion_trail_point_history #(
  parameter int CAPACITY = mth_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [23:0] pos_x, [47:24] pos_y, [71:48] pos_z, [91:72] delta_time, rest zero
  input  logic [mth_pkg::IN_D_W-1:0]    in_tdata,
  // [0] clear_first
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [23:0] out_x, [47:24] out_y, [71:48] out_z, [77:72] point_index,
  // [84:78] point_count, [116:85] total_length, rest zero
  output logic [mth_pkg::OUT_D_W-1:0]   out_tdata,
  // [0] dropped_for_space
  output logic                          out_tuser,
  output logic                          out_tlast,
  input  logic                          cfg_we,
  input  logic [mth_pkg::CFG_A_W-1:0]   cfg_addr,
  input  logic [mth_pkg::CFG_D_W-1:0]   cfg_wdata
);

  localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int TOT_W = mth_pkg::SEG_W + PTR_W;
  localparam int EXT_W = (TOT_W > mth_pkg::TOTAL_W) ? TOT_W : mth_pkg::TOTAL_W + 1;
  localparam int LC_W  = (TOT_W > mth_pkg::MAXL_W) ? TOT_W : mth_pkg::MAXL_W;

  // Ring slot of the point i places after the oldest one.
  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                               input logic [PTR_W-1:0] idx);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, idx};
    if (sum >= (PTR_W+1)'(CAPACITY)) begin
      sum = sum - (PTR_W+1)'(CAPACITY);
    end
    return sum[PTR_W-1:0];
  endfunction

  // Configuration registers.
  logic                          emitting_r, emitting_nxt;
  logic                          mode_r, mode_nxt;
  logic [mth_pkg::LIFE_W-1:0]    life_r, life_nxt;
  logic [mth_pkg::MAXL_W-1:0]    maxl_r, maxl_nxt;
  logic [mth_pkg::MINS_W-1:0]    mins_r, mins_nxt;
  logic [2*mth_pkg::MINS_W-1:0]  minsq_r;

  // Trail state and per-tick working registers.
  mth_pkg::state_t               state_r, state_nxt;
  logic [PTR_W-1:0]              oldest_r, oldest_nxt;
  logic [CNT_W-1:0]              live_r, live_nxt;
  logic [mth_pkg::TIME_W-1:0]    elapsed_r, elapsed_nxt;
  mth_pkg::pos_t                 pos_r, pos_nxt;
  logic [PTR_W-1:0]              idx_r, idx_nxt;
  logic [PTR_W-1:0]              kseg_r, kseg_nxt;
  logic [TOT_W-1:0]              total_r, total_nxt;
  logic                          dropped_r, dropped_nxt;

  // Result register.
  logic                          ovalid_r, ovalid_nxt;
  logic [mth_pkg::OUT_D_W-1:0]   odata_r, odata_nxt;
  logic                          ouser_r, ouser_nxt;
  logic                          olast_r, olast_nxt;

  // Memories: point ring with two read ports, segment lengths with one.
  mth_pkg::entry_t               pt_mem_r [CAPACITY];
  logic [mth_pkg::SEG_W-1:0]     seg_mem_r [CAPACITY];
  logic                          pa_en, pb_en, pw_en, sw_en, sr_en;
  logic [PTR_W-1:0]              pa_addr, pb_addr, pw_addr;
  mth_pkg::entry_t               pw_data;
  mth_pkg::entry_t               pa_q_r, pb_q_r;
  logic [mth_pkg::SEG_W-1:0]     seg_q_r;

  // Arithmetic units.
  logic                          sq_start, sq_valid, sr_done;
  mth_pkg::pos_t                 sq_a, sq_b;
  logic [mth_pkg::D2_W-1:0]      sq_d2;
  logic [mth_pkg::SEG_W-1:0]     sr_root;
  logic                          use_pos;

  logic [mth_pkg::TIME_W:0]      elapsed_sum;
  logic [CNT_W-1:0]              live_clr;
  logic                          in_acc;
  logic [EXT_W-1:0]              tot_ext;
  logic [mth_pkg::TOTAL_W-1:0]   tot_sat;
  logic                          cull_len;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == mth_pkg::ST_IDLE);
  assign tot_ext   = EXT_W'(total_r);
  assign tot_sat   = (tot_ext > EXT_W'({mth_pkg::TOTAL_W{1'b1}})) ? '1
                                                                  : tot_ext[mth_pkg::TOTAL_W-1:0];
  assign cull_len  = (live_r > CNT_W'(1)) && (LC_W'(total_r) > LC_W'(maxl_r));

  assign sq_a = use_pos ? pos_r : pa_q_r.pos;
  assign sq_b = use_pos ? pa_q_r.pos : pb_q_r.pos;

  mth_sqdist u_sqdist (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .pos_a    (sq_a),
    .pos_b    (sq_b),
    .d2_valid (sq_valid),
    .d2       (sq_d2)
  );

  mth_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_valid && (state_r == mth_pkg::ST_SUM_SQ)),
    .radicand (sq_d2),
    .done     (sr_done),
    .root     (sr_root)
  );

  // The square of the minimum section is kept ready for the append test.
  always_ff @(posedge clk) begin
    minsq_r <= mins_r * mins_r;
  end

  always_ff @(posedge clk) begin
    if (pw_en) begin
      pt_mem_r[pw_addr] <= pw_data;
    end
    if (pa_en) begin
      pa_q_r <= pt_mem_r[pa_addr];
    end
    if (pb_en) begin
      pb_q_r <= pt_mem_r[pb_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (sw_en) begin
      seg_mem_r[idx_r] <= sr_root;
    end
    if (sr_en) begin
      seg_q_r <= seg_mem_r[kseg_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mth_pkg::ST_IDLE;
      emitting_r <= 1'b1;
      mode_r     <= 1'b0;
      life_r     <= mth_pkg::LIFE_RESET;
      maxl_r     <= '0;
      mins_r     <= mth_pkg::MINS_RESET;
      oldest_r   <= '0;
      live_r     <= '0;
      elapsed_r  <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      emitting_r <= emitting_nxt;
      mode_r     <= mode_nxt;
      life_r     <= life_nxt;
      maxl_r     <= maxl_nxt;
      mins_r     <= mins_nxt;
      oldest_r   <= oldest_nxt;
      live_r     <= live_nxt;
      elapsed_r  <= elapsed_nxt;
      ovalid_r   <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    idx_r     <= idx_nxt;
    kseg_r    <= kseg_nxt;
    total_r   <= total_nxt;
    dropped_r <= dropped_nxt;
    odata_r   <= odata_nxt;
    ouser_r   <= ouser_nxt;
    olast_r   <= olast_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    emitting_nxt = emitting_r;
    mode_nxt     = mode_r;
    life_nxt     = life_r;
    maxl_nxt     = maxl_r;
    mins_nxt     = mins_r;
    oldest_nxt   = oldest_r;
    live_nxt     = live_r;
    elapsed_nxt  = elapsed_r;
    pos_nxt      = pos_r;
    idx_nxt      = idx_r;
    kseg_nxt     = kseg_r;
    total_nxt    = total_r;
    dropped_nxt  = dropped_r;
    ovalid_nxt   = ovalid_r && !out_tready;
    odata_nxt    = odata_r;
    ouser_nxt    = ouser_r;
    olast_nxt    = olast_r;
    pa_en        = 1'b0;
    pb_en        = 1'b0;
    pa_addr      = slot_of(oldest_r, idx_r);
    pb_addr      = slot_of(oldest_r, idx_r + 1'b1);
    pw_en        = 1'b0;
    pw_addr      = slot_of(oldest_r, PTR_W'(live_r - 1'b1));
    pw_data      = '{pos: pos_r, stamp: elapsed_r};
    sw_en        = 1'b0;
    sr_en        = 1'b0;
    sq_start     = 1'b0;
    use_pos      = 1'b0;
    live_clr     = in_tuser ? '0 : live_r;
    elapsed_sum  = {1'b0, elapsed_r} + (mth_pkg::TIME_W+1)'(in_tdata[91:72]);

    unique case (state_r)
      mth_pkg::ST_IDLE: begin
        if (in_acc) begin
          pos_nxt     = '{x: in_tdata[23:0], y: in_tdata[47:24], z: in_tdata[71:48]};
          elapsed_nxt = elapsed_sum[mth_pkg::TIME_W] ? mth_pkg::TIME_MAX
                                                     : elapsed_sum[mth_pkg::TIME_W-1:0];
          if (in_tuser) begin
            oldest_nxt = '0;
            live_nxt   = '0;
          end
          idx_nxt     = '0;
          kseg_nxt    = '0;
          total_nxt   = '0;
          dropped_nxt = 1'b0;
          if (!emitting_r) begin
            state_nxt = mode_r ? mth_pkg::ST_SUM_RD : mth_pkg::ST_LT_RD;
          end else if (live_clr == '0) begin
            state_nxt = mth_pkg::ST_APPEND;
          end else begin
            state_nxt = mth_pkg::ST_NEW_RD;
          end
        end
      end
      mth_pkg::ST_NEW_RD: begin
        pa_en     = 1'b1;
        pa_addr   = slot_of(oldest_r, PTR_W'(live_r - 1'b1));
        state_nxt = mth_pkg::ST_NEW_GO;
      end
      mth_pkg::ST_NEW_GO: begin
        use_pos   = 1'b1;
        sq_start  = 1'b1;
        state_nxt = mth_pkg::ST_NEW_DIST;
      end
      mth_pkg::ST_NEW_DIST: begin
        if (sq_valid) begin
          if (sq_d2 >= mth_pkg::D2_W'(minsq_r)) begin
            state_nxt = mth_pkg::ST_APPEND;
          end else begin
            // Too close: the newest point moves here and takes the new time.
            pw_en     = 1'b1;
            state_nxt = mode_r ? mth_pkg::ST_SUM_RD : mth_pkg::ST_LT_RD;
          end
        end
      end
      mth_pkg::ST_APPEND: begin
        pw_en = 1'b1;
        if (live_r == CNT_W'(CAPACITY)) begin
          // Full ring: the new point overwrites the oldest one.
          pw_addr     = oldest_r;
          oldest_nxt  = slot_of(oldest_r, PTR_W'(1));
          dropped_nxt = 1'b1;
        end else begin
          pw_addr  = slot_of(oldest_r, PTR_W'(live_r));
          live_nxt = live_r + 1'b1;
        end
        state_nxt = mode_r ? mth_pkg::ST_SUM_RD : mth_pkg::ST_LT_RD;
      end
      mth_pkg::ST_LT_RD: begin
        if (live_r > CNT_W'(1)) begin
          pa_en     = 1'b1;
          pa_addr   = oldest_r;
          state_nxt = mth_pkg::ST_LT_CHK;
        end else begin
          state_nxt = mth_pkg::ST_SUM_RD;
        end
      end
      mth_pkg::ST_LT_CHK: begin
        if (({1'b0, pa_q_r.stamp} + (mth_pkg::TIME_W+1)'(life_r)) < {1'b0, elapsed_r}) begin
          oldest_nxt = slot_of(oldest_r, PTR_W'(1));
          live_nxt   = live_r - 1'b1;
          state_nxt  = mth_pkg::ST_LT_RD;
        end else begin
          state_nxt = mth_pkg::ST_SUM_RD;
        end
      end
      mth_pkg::ST_SUM_RD: begin
        if ((CNT_W'(idx_r) + 1'b1) < live_r) begin
          pa_en     = 1'b1;
          pb_en     = 1'b1;
          state_nxt = mth_pkg::ST_SUM_GO;
        end else begin
          idx_nxt   = '0;
          state_nxt = mode_r ? mth_pkg::ST_LEN_RD : mth_pkg::ST_EMIT_RD;
        end
      end
      mth_pkg::ST_SUM_GO: begin
        sq_start  = 1'b1;
        state_nxt = mth_pkg::ST_SUM_SQ;
      end
      mth_pkg::ST_SUM_SQ: begin
        if (sq_valid) begin
          state_nxt = mth_pkg::ST_SUM_ROOT;
        end
      end
      mth_pkg::ST_SUM_ROOT: begin
        if (sr_done) begin
          sw_en     = 1'b1;
          total_nxt = total_r + TOT_W'(sr_root);
          idx_nxt   = idx_r + 1'b1;
          state_nxt = mth_pkg::ST_SUM_RD;
        end
      end
      mth_pkg::ST_LEN_RD: begin
        if (cull_len) begin
          sr_en     = 1'b1;
          state_nxt = mth_pkg::ST_LEN_SUB;
        end else begin
          state_nxt = mth_pkg::ST_EMIT_RD;
        end
      end
      mth_pkg::ST_LEN_SUB: begin
        total_nxt  = total_r - TOT_W'(seg_q_r);
        oldest_nxt = slot_of(oldest_r, PTR_W'(1));
        live_nxt   = live_r - 1'b1;
        kseg_nxt   = kseg_r + 1'b1;
        state_nxt  = mth_pkg::ST_LEN_RD;
      end
      mth_pkg::ST_EMIT_RD: begin
        pa_en     = 1'b1;
        state_nxt = mth_pkg::ST_EMIT_LD;
      end
      mth_pkg::ST_EMIT_LD: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          if (live_r == '0) begin
            // Empty trail: a single all-zero beat closes the tick.
            odata_nxt = '0;
            ouser_nxt = 1'b0;
            olast_nxt = 1'b1;
            state_nxt = mth_pkg::ST_IDLE;
          end else begin
            odata_nxt = mth_pkg::OUT_D_W'({tot_sat,
                                           mth_pkg::COUNT_W'(live_r),
                                           mth_pkg::IDX_W'(idx_r),
                                           pa_q_r.pos.z, pa_q_r.pos.y, pa_q_r.pos.x});
            ouser_nxt = dropped_r;
            olast_nxt = (CNT_W'(idx_r) + 1'b1) == live_r;
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ((CNT_W'(idx_r) + 1'b1) == live_r) ? mth_pkg::ST_IDLE
                                                           : mth_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = mth_pkg::ST_IDLE;
      end
    endcase

    // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
    if (cfg_we) begin
      unique case (cfg_addr)
        mth_pkg::CFG_EMITTING: begin
          emitting_nxt = cfg_wdata[0];
          if (!emitting_r && cfg_wdata[0]) begin
            oldest_nxt = '0;
            live_nxt   = '0;
          end
        end
        mth_pkg::CFG_LIMIT_MODE: begin
          mode_nxt = cfg_wdata[0];
        end
        mth_pkg::CFG_LIFETIME: begin
          life_nxt = (cfg_wdata < mth_pkg::LIFE_MIN) ? mth_pkg::LIFE_MIN : cfg_wdata;
        end
        mth_pkg::CFG_MAX_LENGTH: begin
          maxl_nxt = cfg_wdata[mth_pkg::MAXL_W-1:0];
        end
        mth_pkg::CFG_MIN_SECTION: begin
          mins_nxt = (cfg_wdata[mth_pkg::MINS_W-1:0] == '0) ? mth_pkg::MINS_RESET
                                                           : cfg_wdata[mth_pkg::MINS_W-1:0];
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;

endmodule
